// File: rtl/core/dswg_pkg.sv
// ----------------------------------------------------------------------------
// dswg_pkg: shared types and constants
// Widths, coefficients, register indexes and pipeline payloads of the
// duty-shaped waveform generator.
// ----------------------------------------------------------------------------
package dswg_pkg;

  localparam int PHASE_BITS  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // Warped angle is Q0.32, the polynomial runs in Q30.
  localparam int ANGLE_BITS = 32;
  localparam int Q_FRAC     = 30;
  localparam int VAL_BITS   = 32;

  // Long division: one leading compare, then STEPS shifted-in bits.
  localparam int STEPS      = ANGLE_BITS - 1;
  localparam int DIV_STAGES = 8;
  localparam int DIV_STEPS  = ANGLE_BITS / DIV_STAGES;

  // Triangle quotient is scaled up by TRI_SHIFT so it shares the divider.
  localparam int TRI_SHIFT = ANGLE_BITS - 1 - SAMPLE_BITS;
  localparam int TMAG_BITS = ANGLE_BITS - TRI_SHIFT;

  localparam int RND_SHIFT   = Q_FRAC - FRAC_BITS;
  localparam int POLY_STAGES = 11;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = PHASE_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_KIND = CFG_INDEX_BITS'(1);

  localparam logic [PHASE_BITS-1:0]  DUTY_RESET = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {FRAC_BITS{1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {FRAC_BITS{1'b0}}};

  // Odd Taylor-like coefficients of sin(pi/2 * u), Q30.
  localparam logic signed [VAL_BITS-1:0] SIN_C1 = 32'sd1686629713;
  localparam logic signed [VAL_BITS-1:0] SIN_C3 = -32'sd693598668;
  localparam logic signed [VAL_BITS-1:0] SIN_C5 = 32'sd85569306;
  localparam logic signed [VAL_BITS-1:0] SIN_C7 = -32'sd5026995;
  localparam logic signed [VAL_BITS-1:0] SIN_C9 = 32'sd172272;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_TRI    = 2'd2
  } wave_kind_t;

  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Side information that rides along with the divider.
  typedef struct packed {
    wave_kind_t kind;
    logic       second;   // sine: second half wave; triangle: negative half
    sample_t    sq;       // square sample, settled at entry
  } tag_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] rem;   // holds the numerator before the first step
    logic [PHASE_BITS-1:0] den;
    logic [STEPS-1:0]      low;   // dividend bits still to shift in
    logic [ANGLE_BITS-1:0] quo;
    tag_t                  tag;
  } div_state_t;

  typedef struct packed {
    logic [Q_FRAC:0]   u;
    logic [Q_FRAC:0]   u2;
    logic              vneg;
    logic [VAL_BITS-1:0] val;
    logic              neg;
    logic              is_sine;
    sample_t           alt;
  } poly_t;

  function automatic logic signed [VAL_BITS-1:0] coef_for_stage(input int k);
    logic signed [VAL_BITS-1:0] c;
    case (k)
      2:       c = SIN_C7;
      4:       c = SIN_C5;
      6:       c = SIN_C3;
      8:       c = SIN_C1;
      default: c = SIN_C9;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/dswg_ifs.sv
// ----------------------------------------------------------------------------
// dswg_ifs: request channels of the waveform generator
// Phase requests, sample results and configuration writes, each with
// valid/ready and a source and a sink view.
// ----------------------------------------------------------------------------
interface dswg_phase_if import dswg_pkg::*; ();
  logic   valid;
  logic   ready;
  phase_t phase;
  modport source (output valid, output phase, input ready);
  modport sink   (input valid, input phase, output ready);
endinterface

interface dswg_sample_if import dswg_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface dswg_cfg_if import dswg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/duty_shaped_waveform_generator_unit.sv
// ----------------------------------------------------------------------------
// duty_shaped_waveform_generator_unit: skewed sine, square, triangle source
// Path: entry stage, divider, fold stage and sine pipeline, then out_rsp.
// Throughput: one request per cycle unless the output stalls; 21 stages.
// Reset: duty 1/2, sine selected, pipeline emptied; no clearing pass.
// ----------------------------------------------------------------------------
module duty_shaped_waveform_generator_unit import dswg_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dswg_phase_if.sink    in_req,
  dswg_sample_if.source out_rsp,
  dswg_cfg_if.sink      cfg_wr
);

  // --------------------------------------------------------------------------
  // Pipeline map
  //   entry stage  : clamp duty, pick segment, numerator and denominator
  //   dswg_div     : 8 stages, 4 quotient bits each (32-bit quotient)
  //   fold stage   : warp to quarter wave, finish triangle and square
  //   dswg_sine    : 11 stages of square / multiply / add / round
  // Every stage holds a valid bit and advances when empty or when the
  // stage after it advances, so bubbles close up under a stalled output.
  // --------------------------------------------------------------------------

  // --------------------------------------------------------------------------
  // Configuration registers. Always ready; unknown indexes are dropped.
  // --------------------------------------------------------------------------
  phase_t     duty_r;
  wave_kind_t kind_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= DUTY_RESET;
      kind_r <= WAVE_SINE;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        CFG_DUTY: duty_r <= cfg_wr.data[PHASE_BITS-1:0];
        CFG_KIND: kind_r <= wave_kind_t'(cfg_wr.data[1:0]);
        default:  ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Entry stage.
  // Sine: warp p so the duty point lands on the half period. Below the duty
  // point divide p by d, above it divide p - d by M - d and add one half
  // turn later. Triangle: four segments, each a ratio num/den scaled to
  // the sample range with half-up rounding; the rounding offset den/2 is
  // fed in as low dividend bits, scaled by TRI_SHIFT.
  // --------------------------------------------------------------------------
  phase_t                d;
  phase_t                p;
  phase_t                d_comp;      // M - d, never zero since d >= 1
  logic                  p_le_d;
  logic [PHASE_BITS:0]   p2;
  phase_t                num;
  phase_t                den;
  logic                  second;
  div_state_t            pre_nxt;
  div_state_t            pre_r;
  logic                  pre_v_r;
  logic                  pre_en;
  logic                  div_in_ready;

  always_comb begin
    d      = (duty_r == '0) ? PHASE_BITS'(1) : duty_r;
    p      = in_req.phase;
    d_comp = '0 - d;
    p_le_d = p <= d;
    p2     = {p, 1'b0};

    if (kind_r == WAVE_TRI) begin
      if (p2 <= {1'b0, d}) begin
        // rising from 0 to +1
        num    = p;
        den    = d;
        second = 1'b0;
      end else if (p_le_d) begin
        // falling from +1 to 0
        num    = d - p;
        den    = d;
        second = 1'b0;
      end else if (p2 <= {1'b1, d}) begin
        // falling from 0 to -1
        num    = p - d;
        den    = d_comp;
        second = 1'b1;
      end else begin
        // rising from -1 back to 0
        num    = '0 - p;
        den    = d_comp;
        second = 1'b1;
      end
    end else begin
      num    = p_le_d ? p : p - d;
      den    = p_le_d ? d : d_comp;
      second = !p_le_d;
    end

    pre_nxt.rem        = num;
    pre_nxt.den        = den;
    pre_nxt.low        = (kind_r == WAVE_TRI) ? (STEPS'(den >> 1) << TRI_SHIFT) : '0;
    pre_nxt.quo        = '0;
    pre_nxt.tag.kind   = kind_r;
    pre_nxt.tag.second = second;
    pre_nxt.tag.sq     = p_le_d ? SAMPLE_MAX : SAMPLE_MIN;
  end

  assign pre_en       = !pre_v_r || div_in_ready;
  assign in_req.ready = pre_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (pre_en) begin
      pre_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_en) begin
      pre_r <= pre_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider
  // --------------------------------------------------------------------------
  logic       div_out_valid;
  logic       div_out_ready;
  div_state_t div_out;

  dswg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pre_v_r),
    .in_ready  (div_in_ready),
    .in_data   (pre_r),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_data  (div_out)
  );

  // --------------------------------------------------------------------------
  // Fold stage.
  // Sine: w is the Q0.32 angle; the top two bits pick the quadrant, odd
  // quadrants mirror the Q30 remainder, the lower half wave flips sign.
  // Triangle: the quotient was scaled up, so shift it back; +1 saturates
  // to the largest positive code, -1 maps to the most negative one.
  // Unused kind: hold a zero sample.
  // --------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] w;
  logic [1:0]            quad;
  logic [Q_FRAC:0]       r_ext;
  logic [TMAG_BITS-1:0]  tmag;
  logic [TMAG_BITS-1:0]  tlim;
  logic [TMAG_BITS-1:0]  tneg;
  sample_t               tri_s;
  poly_t                 post_nxt;
  poly_t                 post_r;
  logic                  post_v_r;
  logic                  post_en;
  logic                  sine_in_ready;

  always_comb begin
    w     = div_out.quo + {div_out.tag.second, {(ANGLE_BITS-1){1'b0}}};
    quad  = w[ANGLE_BITS-1:ANGLE_BITS-2];
    r_ext = {1'b0, w[Q_FRAC-1:0]};

    tmag = div_out.quo[ANGLE_BITS-1:TRI_SHIFT];
    if (div_out.tag.second) begin
      tlim  = (tmag > (TMAG_BITS'(1) << FRAC_BITS)) ? (TMAG_BITS'(1) << FRAC_BITS) : tmag;
      tneg  = '0 - tlim;
      tri_s = tneg[SAMPLE_BITS-1:0];
    end else begin
      tlim  = tmag;
      tneg  = '0;
      tri_s = (tmag > TMAG_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX : tmag[SAMPLE_BITS-1:0];
    end

    post_nxt.u    = quad[0] ? ((Q_FRAC+1)'(1) << Q_FRAC) - r_ext : r_ext;
    post_nxt.u2   = '0;
    post_nxt.vneg = 1'b0;
    post_nxt.val  = '0;
    post_nxt.neg  = quad[1];

    case (div_out.tag.kind)
      WAVE_SINE: begin
        post_nxt.is_sine = 1'b1;
        post_nxt.alt     = '0;
      end
      WAVE_SQUARE: begin
        post_nxt.is_sine = 1'b0;
        post_nxt.alt     = div_out.tag.sq;
      end
      WAVE_TRI: begin
        post_nxt.is_sine = 1'b0;
        post_nxt.alt     = tri_s;
      end
      default: begin
        post_nxt.is_sine = 1'b0;
        post_nxt.alt     = '0;
      end
    endcase
  end

  assign post_en       = !post_v_r || sine_in_ready;
  assign div_out_ready = post_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_v_r <= 1'b0;
    end else if (post_en) begin
      post_v_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (post_en) begin
      post_r <= post_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sine polynomial. Non-sine samples pass through in the alt field; the
  // last stage of this pipeline is the output register.
  // --------------------------------------------------------------------------
  poly_t sine_out;

  dswg_sine u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (post_v_r),
    .in_ready  (sine_in_ready),
    .in_data   (post_r),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_data  (sine_out)
  );

  assign out_rsp.sample = sine_out.alt;

endmodule

// File: rtl/core/dswg_div.sv
// ----------------------------------------------------------------------------
// dswg_div: pipelined restoring divider
// Produces a 32-bit quotient, DIV_STEPS quotient bits per stage, with the
// tag carried alongside.
// ----------------------------------------------------------------------------
module dswg_div import dswg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_state_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output div_state_t out_data
);

  // First step of the first stage settles the leading quotient bit from
  // the numerator alone; every other step shifts in one dividend bit.
  function automatic div_state_t div_stage(input div_state_t s, input logic first);
    div_state_t          o;
    logic [PHASE_BITS:0] r2;
    logic                ge;
    o = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (first && i == 0) begin
        r2 = {1'b0, o.rem};
      end else begin
        r2    = {o.rem, o.low[STEPS-1]};
        o.low = {o.low[STEPS-2:0], 1'b0};
      end
      ge    = r2 >= {1'b0, o.den};
      r2    = ge ? r2 - {1'b0, o.den} : r2;
      o.rem = r2[PHASE_BITS-1:0];
      o.quo = {o.quo[ANGLE_BITS-2:0], ge};
    end
    return o;
  endfunction

  logic             v_r  [DIV_STAGES];
  div_state_t       st_r [DIV_STAGES];
  logic [DIV_STAGES:0] en;

  assign en[DIV_STAGES] = out_ready;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic       v_nxt;
    div_state_t st_nxt;

    if (k == 0) begin : g_first
      assign v_nxt  = in_valid;
      assign st_nxt = div_stage(in_data, 1'b1);
    end else begin : g_next
      assign v_nxt  = v_r[k-1];
      assign st_nxt = div_stage(st_r[k-1], 1'b0);
    end

    // Advance when this stage is empty or its successor moves on.
    assign en[k] = !v_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[DIV_STAGES-1];
  assign out_data  = st_r[DIV_STAGES-1];

endmodule

// File: rtl/core/dswg_sine.sv
// ----------------------------------------------------------------------------
// dswg_sine: quarter-wave sine polynomial pipeline
// Squares u, runs the Horner chain one multiply or one add per stage,
// then rounds, saturates and signs the sample.
// ----------------------------------------------------------------------------
module dswg_sine import dswg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  poly_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output poly_t out_data
);

  function automatic poly_t poly_square(input poly_t s);
    poly_t                   o;
    logic [2*Q_FRAC+1:0]     prod;
    o      = s;
    prod   = (2*Q_FRAC+2)'(s.u) * (2*Q_FRAC+2)'(s.u);
    o.u2   = prod[2*Q_FRAC:Q_FRAC];
    o.vneg = 1'b0;
    o.val  = VAL_BITS'(SIN_C9);
    return o;
  endfunction

  // Magnitude product truncated toward zero; the sign rides in vneg.
  function automatic poly_t poly_mul(input poly_t s, input logic [Q_FRAC:0] m);
    poly_t                       o;
    logic [VAL_BITS+Q_FRAC:0]    prod;
    o     = s;
    prod  = (VAL_BITS+Q_FRAC+1)'(s.val) * (VAL_BITS+Q_FRAC+1)'(m);
    o.val = prod[VAL_BITS+Q_FRAC-1:Q_FRAC];
    return o;
  endfunction

  function automatic poly_t poly_add(input poly_t s, input logic signed [VAL_BITS-1:0] c);
    poly_t                     o;
    logic signed [VAL_BITS+1:0] sv;
    logic signed [VAL_BITS+1:0] sum;
    o   = s;
    sv  = signed'({2'b00, s.val});
    if (s.vneg) begin
      sv = -sv;
    end
    sum    = signed'({{2{c[VAL_BITS-1]}}, c}) + sv;
    o.vneg = sum[VAL_BITS+1];
    o.val  = sum[VAL_BITS+1] ? VAL_BITS'(-sum) : sum[VAL_BITS-1:0];
    return o;
  endfunction

  // Drop negative results, round half up to the sample grid, saturate.
  function automatic poly_t poly_round(input poly_t s);
    poly_t               o;
    logic [VAL_BITS:0]   t;
    logic [VAL_BITS:0]   mag;
    logic [SAMPLE_BITS-1:0] m;
    o   = s;
    t   = s.vneg ? '0 : {1'b0, s.val};
    t   = t + ((VAL_BITS+1)'(1) << (RND_SHIFT - 1));
    mag = t >> RND_SHIFT;
    m   = (mag > (VAL_BITS+1)'(SAMPLE_MAX)) ? SAMPLE_MAX : mag[SAMPLE_BITS-1:0];
    if (s.is_sine) begin
      o.alt = s.neg ? sample_t'(-m) : sample_t'(m);
    end
    return o;
  endfunction

  logic                 v_r  [POLY_STAGES];
  poly_t                st_r [POLY_STAGES];
  logic [POLY_STAGES:0] en;

  assign en[POLY_STAGES] = out_ready;

  for (genvar k = 0; k < POLY_STAGES; k++) begin : g_stage
    logic  v_nxt;
    poly_t st_nxt;

    if (k == 0) begin : g_sq
      assign v_nxt  = in_valid;
      assign st_nxt = poly_square(in_data);
    end else if (k == POLY_STAGES - 1) begin : g_rnd
      assign v_nxt  = v_r[k-1];
      assign st_nxt = poly_round(st_r[k-1]);
    end else if (k == POLY_STAGES - 2) begin : g_mu
      assign v_nxt  = v_r[k-1];
      assign st_nxt = poly_mul(st_r[k-1], st_r[k-1].u);
    end else if (k % 2 == 1) begin : g_mu2
      assign v_nxt  = v_r[k-1];
      assign st_nxt = poly_mul(st_r[k-1], st_r[k-1].u2);
    end else begin : g_add
      assign v_nxt  = v_r[k-1];
      assign st_nxt = poly_add(st_r[k-1], coef_for_stage(k));
    end

    assign en[k] = !v_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[POLY_STAGES-1];
  assign out_data  = st_r[POLY_STAGES-1];

endmodule
